// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/kqvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kqvt_pkg
// Types, codes and character constants of the key / quoted-value tokenizer.
// ----------------------------------------------------------------------------
package kqvt_pkg;

  localparam int unsigned KEY_LEN_W   = 8;
  localparam int unsigned VAL_LEN_W   = 12;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [KEY_LEN_W-1:0] KEY_MAX_RST = 8'd31;
  localparam logic [VAL_LEN_W-1:0] VAL_MAX_RST = 12'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MAX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_MAX = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    ST_SKIP    = 3'd0,
    ST_COMMENT = 3'd1,
    ST_KEY     = 3'd2,
    ST_SEEK    = 3'd3,
    ST_VALUE   = 3'd4,
    ST_QUOTE   = 3'd5
  } scan_e;

  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_END   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_KEY_LONG = 3'd1,
    ERR_KEY_EOT  = 3'd2,
    ERR_VAL_OPEN = 3'd3,
    ERR_VAL_LONG = 3'd4
  } err_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       code;
  } res_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] data, err_e code);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.code = code;
    return r;
  endfunction

endpackage

// ----- design/kqvt_scan.sv -----
// ----------------------------------------------------------------------------
// kqvt_scan
// Scanner state machine: consumes one text item per transfer and produces
// up to two results for the result queue.
// ----------------------------------------------------------------------------
module kqvt_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_text_i,
  input  logic [kqvt_pkg::KEY_LEN_W-1:0] key_max_i,
  input  logic [kqvt_pkg::VAL_LEN_W-1:0] val_max_i,
  output kqvt_pkg::push_t                push_o
);
  import kqvt_pkg::*;

  scan_e                state_q, state_d;
  logic [KEY_LEN_W-1:0] key_cnt_q, key_cnt_d;
  logic [VAL_LEN_W-1:0] val_cnt_q, val_cnt_d;

  logic is_blank, is_key_end, is_quote, is_hash;
  logic key_full, val_full, bk_full;
  logic bk_emit;
  res_t bk_res;

  assign is_key_end = (text_byte_i == CH_SPACE) || (text_byte_i == CH_CR) ||
                      (text_byte_i == CH_NL);
  assign is_blank   = is_key_end || (text_byte_i == CH_TAB);
  assign is_quote   = (text_byte_i == CH_QUOTE);
  assign is_hash    = (text_byte_i == CH_HASH);
  assign key_full   = (key_cnt_q >= key_max_i);
  assign val_full   = (val_cnt_q >= val_max_i);
  // a new key starts from a zero count, so only a zero limit makes it full
  assign bk_full    = (key_max_i == '0);

  // first byte before a key
  always_comb begin
    bk_emit = !is_blank && !is_hash;
    if (bk_full) begin
      bk_res = mk_res(KIND_ERROR, 8'h00, ERR_KEY_LONG);
    end else begin
      bk_res = mk_res(KIND_KEY, text_byte_i, ERR_NONE);
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    key_cnt_d = key_cnt_q;
    val_cnt_d = val_cnt_q;
    if (fire_i) begin
      if (end_of_text_i) begin
        state_d   = ST_SKIP;
        key_cnt_d = '0;
        val_cnt_d = '0;
      end else begin
        unique case (state_q)
          ST_COMMENT: begin
            if (text_byte_i == CH_NL) state_d = ST_SKIP;
          end
          ST_KEY: begin
            if (is_key_end) begin
              state_d = ST_SEEK;
            end else if (key_full) begin
              state_d   = ST_SKIP;
              key_cnt_d = '0;
              val_cnt_d = '0;
            end else begin
              key_cnt_d = key_cnt_q + 1'b1;
            end
          end
          ST_SEEK: begin
            if (is_quote) begin
              val_cnt_d = '0;
              state_d   = ST_VALUE;
            end
          end
          ST_VALUE: begin
            if (is_quote) begin
              state_d = ST_QUOTE;
            end else if (val_full) begin
              state_d   = ST_SKIP;
              key_cnt_d = '0;
              val_cnt_d = '0;
            end else begin
              val_cnt_d = val_cnt_q + 1'b1;
            end
          end
          ST_QUOTE: begin
            if (is_quote) begin
              if (val_full) begin
                state_d   = ST_SKIP;
                key_cnt_d = '0;
                val_cnt_d = '0;
              end else begin
                state_d   = ST_VALUE;
                val_cnt_d = val_cnt_q + 1'b1;
              end
            end else begin
              // pair closed, byte may start the next key
              key_cnt_d = '0;
              val_cnt_d = '0;
              state_d   = ST_SKIP;
              if (is_hash) begin
                state_d = ST_COMMENT;
              end else if (bk_emit && !bk_full) begin
                state_d   = ST_KEY;
                key_cnt_d = KEY_LEN_W'(1);
              end
            end
          end
          default: begin
            // skipping, and recovery from unused codes
            key_cnt_d = '0;
            val_cnt_d = '0;
            state_d   = ST_SKIP;
            if (is_hash) begin
              state_d = ST_COMMENT;
            end else if (bk_emit && !bk_full) begin
              state_d   = ST_KEY;
              key_cnt_d = KEY_LEN_W'(1);
            end
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    push_o.num = 2'd0;
    push_o.r0  = mk_res(KIND_DONE, 8'h00, ERR_NONE);
    push_o.r1  = mk_res(KIND_DONE, 8'h00, ERR_NONE);
    if (fire_i) begin
      if (end_of_text_i) begin
        push_o.num = 2'd1;
        unique case (state_q)
          ST_KEY: push_o.r0 = mk_res(KIND_ERROR, 8'h00, ERR_KEY_EOT);
          ST_SEEK, ST_VALUE: push_o.r0 = mk_res(KIND_ERROR, 8'h00, ERR_VAL_OPEN);
          ST_QUOTE: begin
            push_o.num = 2'd2;
            push_o.r0  = mk_res(KIND_END, 8'h00, ERR_NONE);
          end
          default: push_o.r0 = mk_res(KIND_DONE, 8'h00, ERR_NONE);
        endcase
      end else begin
        unique case (state_q)
          ST_COMMENT, ST_SEEK: push_o.num = 2'd0;
          ST_KEY: begin
            if (!is_key_end) begin
              push_o.num = 2'd1;
              push_o.r0  = key_full ? mk_res(KIND_ERROR, 8'h00, ERR_KEY_LONG)
                                    : mk_res(KIND_KEY, text_byte_i, ERR_NONE);
            end
          end
          ST_VALUE, ST_QUOTE: begin
            if (is_quote == (state_q == ST_QUOTE)) begin
              push_o.num = 2'd1;
              push_o.r0  = val_full ? mk_res(KIND_ERROR, 8'h00, ERR_VAL_LONG)
                                    : mk_res(KIND_VALUE, text_byte_i, ERR_NONE);
            end else if (state_q == ST_QUOTE) begin
              push_o.num = bk_emit ? 2'd2 : 2'd1;
              push_o.r0  = mk_res(KIND_END, 8'h00, ERR_NONE);
              push_o.r1  = bk_res;
            end
          end
          default: begin
            if (bk_emit) begin
              push_o.num = 2'd1;
              push_o.r0  = bk_res;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SKIP;
      key_cnt_q <= '0;
      val_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      key_cnt_q <= key_cnt_d;
      val_cnt_q <= val_cnt_d;
    end
  end

endmodule

// ----- design/kqvt_fifo.sv -----
// ----------------------------------------------------------------------------
// kqvt_fifo
// Small result queue: takes up to two results a cycle, hands out one when ready.
// ----------------------------------------------------------------------------
module kqvt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kqvt_pkg::push_t push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kqvt_pkg::res_t  head_o
);
  import kqvt_pkg::*;

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // room for a two-result item
  assign room_o      = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.num);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d    = cnt_q + FIFO_CNT_W'(push_i.num) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_ptr_q + 1'b1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- design/key_quoted_value_tokenizer.sv -----
// ----------------------------------------------------------------------------
// key_quoted_value_tokenizer
// Streams key bytes, quoted value bytes and pair marks out of config text.
// ----------------------------------------------------------------------------
// One text item is taken per cycle and scanned in the cycle of its transfer;
// its results (at most two) land in a four-entry result queue that drains one
// result per cycle. in_ready_o is low while the queue holds three or more
// results, so the input rate is set by the output side: one item per cycle
// while results are taken every cycle. An item that yields two results (a pair
// end followed by another result) leaves one extra result queued; once such
// items have built the backlog up to three results, the input waits until one is taken.
// Key and value bytes leave before their pair is complete; on an error result
// the consumer drops the open pair.
// Register writes are always accepted and act on the next item.
module key_quoted_value_tokenizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kqvt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kqvt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      kind_o,
  output logic [7:0]                      out_byte_o,
  output logic [2:0]                      error_code_o
);
  import kqvt_pkg::*;

  logic [KEY_LEN_W-1:0] key_max_q;
  logic [VAL_LEN_W-1:0] val_max_q;
  logic                 fire;
  push_t                push;
  res_t                 head;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_max_q <= KEY_MAX_RST;
      val_max_q <= VAL_MAX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_MAX: key_max_q <= cfg_data_i[KEY_LEN_W-1:0];
        REG_VAL_MAX: val_max_q <= cfg_data_i[VAL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  kqvt_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .key_max_i     (key_max_q),
    .val_max_i     (val_max_q),
    .push_o        (push)
  );

  kqvt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign out_byte_o   = head.data;
  assign error_code_o = head.code;

endmodule

// ----- design/kqvt_checker.sv -----
// ----------------------------------------------------------------------------
// kqvt_checker
// Port-level checks on the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kqvt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] error_code_o
);
  import kqvt_pkg::*;

  // a result stays offered until its transfer
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // error code present exactly on error results
  `ASSERT_IMPLIES(a_code_kind, clk_i, rst_ni, out_valid_o,
    (kind_o == KIND_ERROR) == (error_code_o != ERR_NONE))
  // marks carry no character
  `ASSERT_IMPLIES(a_mark_zero, clk_i, rst_ni,
    out_valid_o && kind_o != KIND_KEY && kind_o != KIND_VALUE, out_byte_o == 8'h00)
  // input backpressure only comes from pending results
  `ASSERT_IMPLIES(a_stall_pending, clk_i, rst_ni, !in_ready_o, out_valid_o)

endmodule

bind key_quoted_value_tokenizer kqvt_checker u_kqvt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .out_byte_o   (out_byte_o),
  .error_code_o (error_code_o)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_quoted_value_tokenizer. Text bytes and end marks
// go in with random gaps while the token side stalls at random, save in a last
// back-to-back run. A scanner model built into the bench predicts each token.
// Every token that comes out is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import kqvt_pkg::*;

  localparam int DRAIN_LIMIT = 20000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_KEY_MAX;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            text_byte_i   = '0;
  logic                  end_of_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [2:0]            kind_o;
  logic [7:0]            out_byte_o;
  logic [2:0]            error_code_o;

  key_quoted_value_tokenizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .error_code_o (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  // scanner model state and limits
  scan_e                scan_q  = ST_SKIP;
  logic [KEY_LEN_W-1:0] key_cnt = '0;
  logic [KEY_LEN_W-1:0] key_lim = KEY_MAX_RST;
  logic [VAL_LEN_W-1:0] val_cnt = '0;
  logic [VAL_LEN_W-1:0] val_lim = VAL_MAX_RST;

  res_t expected_tokens[$];
  int   fail_count = 0;
  int   items_sent = 0;
  bit   gaps_on    = 1'b1;
  bit   stalls_on  = 1'b1;
  int   stall_left = 0;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] %s", $time, what);
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
  endfunction

  // tab is a key character, so it does not close a key
  function automatic bit ends_key(input logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_NL;
  endfunction

  task automatic queue_token(input kind_e kind, input logic [7:0] data, input err_e code);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.code = code;
    expected_tokens.push_back(r);
  endtask

  task automatic clear_scan();
    scan_q  = ST_SKIP;
    key_cnt = '0;
    val_cnt = '0;
  endtask

  task automatic raise_error(input err_e code);
    clear_scan();
    queue_token(KIND_ERROR, 8'h00, code);
  endtask

  task automatic open_key(input logic [7:0] c);
    if (is_blank(c)) begin
    end else if (c == CH_HASH) begin
      scan_q = ST_COMMENT;
    end else if (key_cnt >= key_lim) begin
      raise_error(ERR_KEY_LONG);
    end else begin
      key_cnt = KEY_LEN_W'(1);
      scan_q  = ST_KEY;
      queue_token(KIND_KEY, c, ERR_NONE);
    end
  endtask

  task automatic add_value_char(input logic [7:0] c);
    if (val_cnt >= val_lim) begin
      raise_error(ERR_VAL_LONG);
    end else begin
      val_cnt = val_cnt + 1'b1;
      scan_q  = ST_VALUE;
      queue_token(KIND_VALUE, c, ERR_NONE);
    end
  endtask

  task automatic predict_token(input logic [7:0] c, input logic eot);
    if (eot) begin
      case (scan_q)
        ST_KEY:            raise_error(ERR_KEY_EOT);
        ST_SEEK, ST_VALUE: raise_error(ERR_VAL_OPEN);
        default: begin
          // a pending closing quote ends the pair before the text
          if (scan_q == ST_QUOTE) queue_token(KIND_END, 8'h00, ERR_NONE);
          clear_scan();
          queue_token(KIND_DONE, 8'h00, ERR_NONE);
        end
      endcase
    end else begin
      case (scan_q)
        ST_SKIP: open_key(c);
        ST_COMMENT: begin
          if (c == CH_NL) scan_q = ST_SKIP;
        end
        ST_KEY: begin
          if (ends_key(c)) begin
            scan_q = ST_SEEK;
          end else if (key_cnt >= key_lim) begin
            raise_error(ERR_KEY_LONG);
          end else begin
            key_cnt = key_cnt + 1'b1;
            queue_token(KIND_KEY, c, ERR_NONE);
          end
        end
        ST_SEEK: begin
          if (c == CH_QUOTE) begin
            val_cnt = '0;
            scan_q  = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (c == CH_QUOTE) scan_q = ST_QUOTE;
          else add_value_char(c);
        end
        ST_QUOTE: begin
          if (c == CH_QUOTE) begin
            add_value_char(c);
          end else begin
            // closing quote confirmed; this byte may start the next key
            queue_token(KIND_END, 8'h00, ERR_NONE);
            clear_scan();
            open_key(c);
          end
        end
        default: begin
          clear_scan();
          open_key(c);
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d byte %02h code %0d",
                                    kind_o, out_byte_o, error_code_o));
        end else begin
          want = expected_tokens.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
          if (out_byte_o !== want.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte_o, want.data));
          if (error_code_o !== want.code)
            report_mismatch($sformatf("error code %0d, expected %0d",
                                      error_code_o, want.code));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_KEY_MAX) key_lim = cfg_data_i[KEY_LEN_W-1:0];
        else if (cfg_index_i == REG_VAL_MAX) val_lim = cfg_data_i[VAL_LEN_W-1:0];
      end
      if (in_valid_i && in_ready_o) predict_token(text_byte_i, end_of_text_i);
    end
  end

  // token side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [7:0] c, input logic eot);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    text_byte_i   = c;
    end_of_text_i = eot;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    items_sent++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic settle(input int limit);
    int waited;
    waited = 0;
    while (expected_tokens.size() != 0 && waited < limit) begin
      @(negedge clk_i);
      waited++;
    end
    // a token the model did not expect may still be queued
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_limits(input int key_max, input int val_max);
    settle(DRAIN_LIMIT);
    write_reg(REG_KEY_MAX, CFG_DATA_W'(key_max));
    write_reg(REG_VAL_MAX, CFG_DATA_W'(val_max));
  endtask

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_NL;
      4:       return CH_HASH;
      default: return CH_QUOTE;
    endcase
  endfunction

  function automatic logic [7:0] key_byte(input bit first);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? special_byte() : 8'($urandom_range(0, 255));
    end while (ends_key(c) || (first && (c == CH_TAB || c == CH_HASH)));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte(input bit key_end);
    logic [7:0] c;
    do c = special_byte(); while (!(key_end ? ends_key(c) : is_blank(c)));
    return c;
  endfunction

  function automatic logic [7:0] other_byte(input logic [7:0] avoid);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? special_byte() : 8'($urandom_range(0, 255));
    end while (c == avoid);
    return c;
  endfunction

  // mostly short, now and then right at or one past a small limit
  function automatic int pick_len(input int lim);
    if (lim <= 32 && $urandom_range(0, 5) == 0) return lim + $urandom_range(0, 1);
    return $urandom_range(1, (lim < 6) ? lim : 6);
  endfunction

  task automatic send_key(input int len);
    send_item(key_byte(1'b1), 1'b0);
    for (int i = 1; i < len; i++) send_item(key_byte(1'b0), 1'b0);
  endtask

  task automatic send_value(input int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(0, 7) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
      send_item(c, 1'b0);
      if (c == CH_QUOTE) send_item(c, 1'b0);
    end
  endtask

  task automatic send_comment(input bit closed);
    send_item(CH_HASH, 1'b0);
    repeat ($urandom_range(0, 4)) send_item(other_byte(CH_NL), 1'b0);
    if (closed) send_item(CH_NL, 1'b0);
  endtask

  task automatic send_random_text();
    if ($urandom_range(0, 19) == 0) begin
      // noise, weighted toward the characters the scanner decodes
      repeat ($urandom_range(1, 12)) begin
        send_item($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)), 1'b0);
      end
      send_end();
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 3))
          0:       repeat ($urandom_range(1, 3)) send_item(blank_byte(1'b0), 1'b0);
          1:       send_comment(1'b1);
          default: ;
        endcase
        send_key(pick_len(key_lim));
        send_item(blank_byte(1'b1), 1'b0);
        repeat ($urandom_range(0, 2)) send_item(other_byte(CH_QUOTE), 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_value(($urandom_range(0, 9) == 0) ? 0 : pick_len(val_lim));
        send_item(CH_QUOTE, 1'b0);
        if ($urandom_range(0, 39) == 0) settle(DRAIN_LIMIT);
      end
      // sometimes the text stops in the middle of something
      case ($urandom_range(0, 9))
        0: send_key($urandom_range(1, 3));
        1: begin
          send_key(1);
          send_item(blank_byte(1'b1), 1'b0);
        end
        2: begin
          send_key(1);
          send_item(blank_byte(1'b1), 1'b0);
          send_item(CH_QUOTE, 1'b0);
          send_value($urandom_range(0, 3));
        end
        3:       send_comment(1'b0);
        default: ;
      endcase
      send_end();
    end
  endtask

  task automatic run_texts(input int upto);
    while (items_sent < upto) send_random_text();
  endtask

  // blanks, comment, tab inside a key, junk before the quote, doubled quote,
  // NUL and 0xFF bytes, a key right after a closing quote, empty value
  task automatic test_pairs_and_quotes();
    send_text("\t#c\n");
    send_item(8'hFF, 1'b0);
    send_text("\t x\"\"\"");
    send_item(8'h00, 1'b0);
    send_text("\"k");
    send_item(CH_CR, 1'b0);
    send_text("\"\"");
    send_end();
  endtask

  task automatic test_end_of_text();
    send_end();
    send_text("#");
    send_end();
    send_text("z");
    send_end();
    send_text("z\n");
    send_end();
    send_text("z \"v");
    send_end();
  endtask

  // one-character limits: long key, long value, long value on a doubled quote
  task automatic test_length_limits();
    set_limits(1, 1);
    send_text("ab");
    send_text("a \"xy");
    send_text("a \"x\"\"");
    send_end();
  endtask

  task automatic test_random_texts();
    set_limits(255, 4095);
    run_texts(250);
    // hold the sender mid-value until everything has drained
    send_text("pause \"mid");
    settle(DRAIN_LIMIT);
    send_text("\"\n");
    run_texts(420);
    set_limits(3, 5);
    run_texts(650);
    set_limits($urandom_range(1, 12), $urandom_range(1, 16));
    run_texts(850);
  endtask

  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_limits(KEY_MAX_RST, VAL_MAX_RST);
    run_texts(1150);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_pairs_and_quotes();
    test_end_of_text();
    test_length_limits();
    test_random_texts();
    test_back_to_back();
    settle(DRAIN_LIMIT);
    repeat (8) @(negedge clk_i);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never came out", expected_tokens.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/kqvt_pkg.sv
design/kqvt_scan.sv
design/kqvt_fifo.sv
design/key_quoted_value_tokenizer.sv
design/kqvt_checker.sv
tb/tb.sv
